@@ rtl/keypad_sum_decimal_display_macros.svh @@
// Assertion macros used by the keypad/display back end
`ifndef KEYPAD_SUM_DECIMAL_DISPLAY_MACROS_SVH
`define KEYPAD_SUM_DECIMAL_DISPLAY_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KSSD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define KSSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define KSSD_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define KSSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/kssd_pkg.sv @@
package kssd_pkg;

  // default sizing
  localparam int NUM_DIGITS_DEF       = 8;
  localparam int DEBOUNCE_SAMPLES_DEF = 3;

  // binary total and its full decimal width
  localparam int TOTAL_W    = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;

  // request kinds
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // segments shown on scan results (all off)
  localparam logic [7:0] SEG_BLANK = 8'hff;

  typedef struct packed {
    logic       op;
    logic [3:0] column_lines;
    logic [3:0] row_lines;
  } item_t;

  typedef struct packed {
    logic [4:0]         key_code;
    logic [TOTAL_W-1:0] total;
    logic [7:0]         digit_enable;
    logic [7:0]         segments;
  } result_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       op;
    logic [4:0] key_code;
  } cmd_t;

  // common-anode pattern for one decimal digit, dp off
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hf8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = 8'hc0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/kssd_front.sv @@
module kssd_front #(
  parameter int DEBOUNCE_SAMPLES = kssd_pkg::DEBOUNCE_SAMPLES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kssd_pkg::item_t item,
  input  logic            q_full,
  output logic            q_push,
  output kssd_pkg::cmd_t  q_cmd
);

  localparam int CNT_W = $clog2(DEBOUNCE_SAMPLES + 1);

  logic [CNT_W-1:0] press_count;
  logic [CNT_W-1:0] press_count_next;
  logic [3:0]       cols_low;
  logic [3:0]       rows_low;
  logic [1:0]       col_sel;
  logic [1:0]       row_sel;
  logic [4:0]       decoded;
  logic [4:0]       code;

  assign q_push   = push && !q_full;
  assign cols_low = ~item.column_lines;
  assign rows_low = ~item.row_lines;

  // pick lowest pressed column and highest active row
  always_comb begin
    col_sel = 2'd0;
    for (int c = 3; c >= 0; c--) begin
      if (cols_low[c]) col_sel = 2'(c);
    end
    row_sel = 2'd0;
    for (int r = 1; r <= 3; r++) begin
      if (rows_low[r]) row_sel = 2'(r);
    end
    decoded = (rows_low == 4'd0) ? 5'd0 : 5'(col_sel) + 5'd1 + 5'({row_sel, 2'b00});
  end

  // advance debounce counter, accept key on the sample that reaches the limit
  always_comb begin
    press_count_next = press_count;
    code             = 5'd0;
    if (item.op == kssd_pkg::OP_SCAN) begin
      if (cols_low != 4'd0) begin
        if (press_count < CNT_W'(DEBOUNCE_SAMPLES)) begin
          press_count_next = press_count + CNT_W'(1);
          if (press_count_next == CNT_W'(DEBOUNCE_SAMPLES)) code = decoded;
        end
      end else begin
        press_count_next = '0;
      end
    end
  end

  assign q_cmd.op       = item.op;
  assign q_cmd.key_code = code;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_count <= '0;
    end else if (q_push) begin
      press_count <= press_count_next;
    end
  end

endmodule

@@ rtl/kssd_queue.sv @@
module kssd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  kssd_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd,
  output kssd_pkg::cmd_t rd_cmd,
  output logic           nonempty
);

  kssd_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rd_cmd   = slots[rd_ptr];

  // hold requests in a two-entry ring
  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/kssd_back.sv @@
`include "keypad_sum_decimal_display_macros.svh"

module kssd_back #(
  parameter int NUM_DIGITS = kssd_pkg::NUM_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_nonempty,
  input  kssd_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output kssd_pkg::result_t result
);

  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int BIT_W = $clog2(kssd_pkg::TOTAL_W);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CONV = 1'b1;

  logic                          state;
  logic [kssd_pkg::TOTAL_W-1:0]  running_total;
  logic [kssd_pkg::TOTAL_W-1:0]  sum;
  logic [kssd_pkg::TOTAL_W-1:0]  bin;
  logic [kssd_pkg::BCD_W-1:0]    bcd;
  logic [kssd_pkg::BCD_W-1:0]    bcd_adj;
  logic [kssd_pkg::BCD_W-1:0]    bcd_next;
  logic [BIT_W-1:0]              bit_cnt;
  logic [3:0]                    digit_store [NUM_DIGITS];
  logic [IDX_W-1:0]              refresh_index;
  logic [7:0]                    enable_onehot;
  logic                          out_valid;
  logic                          out_free;

  assign empty   = !out_valid;
  assign out_free = !out_valid || pop;
  assign q_pop   = (state == ST_IDLE) && q_nonempty && out_free;
  assign sum     = running_total + kssd_pkg::TOTAL_W'(q_cmd.key_code);

  // one double-dabble step: add 3 to digits at 5 or above, then shift in next bit
  always_comb begin
    for (int k = 0; k < kssd_pkg::BCD_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
    bcd_next = {bcd_adj[kssd_pkg::BCD_W-2:0], bin[kssd_pkg::TOTAL_W-1]};
  end

  // one-hot select for the digit being refreshed, none past the eighth
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      enable_onehot[j] = (32'(refresh_index) == j);
    end
  end

  // issue requests and run the decimal conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      running_total <= '0;
      bit_cnt       <= '0;
      refresh_index <= '0;
      out_valid     <= 1'b0;
      for (int k = 0; k < NUM_DIGITS; k++) digit_store[k] <= 4'd0;
    end else begin
      // refill the output on issue, otherwise drop it once popped
      if (q_pop) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_cmd.op == kssd_pkg::OP_SCAN) begin
              running_total <= sum;
              bin           <= sum;
              bcd           <= '0;
              bit_cnt       <= '0;
              state         <= ST_CONV;
              result        <= '{key_code: q_cmd.key_code, total: sum,
                                 digit_enable: 8'd0, segments: kssd_pkg::SEG_BLANK};
            end else begin
              result <= '{key_code: 5'd0, total: running_total,
                          digit_enable: enable_onehot,
                          segments: kssd_pkg::seg_of(digit_store[refresh_index])};
              if (32'(refresh_index) == NUM_DIGITS - 1) refresh_index <= '0;
              else refresh_index <= refresh_index + IDX_W'(1);
            end
          end
        end
        ST_CONV: begin
          // counter wraps back to zero on the last step
          bcd     <= bcd_next;
          bin     <= {bin[kssd_pkg::TOTAL_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + BIT_W'(1);
          if (bit_cnt == BIT_W'(kssd_pkg::TOTAL_W - 1)) begin
            // units digit lands in the last entry
            for (int k = 0; k < NUM_DIGITS; k++) begin
              digit_store[k] <= bcd_next[4*(NUM_DIGITS-1-k) +: 4];
            end
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `KSSD_ASSERT_NOW(a_no_issue_in_conv, clk, rst, state == ST_CONV, !q_pop)
  `KSSD_ASSERT_NEXT(a_scan_starts_conv, clk, rst, q_pop && q_cmd.op == kssd_pkg::OP_SCAN, state == ST_CONV && out_valid)
  `KSSD_ASSERT_NOW(a_count_idle_zero, clk, rst, state == ST_IDLE, bit_cnt == '0)
  `KSSD_ASSERT_NOW(a_enable_onehot, clk, rst, out_valid, $onehot0(result.digit_enable))

endmodule

@@ rtl/keypad_sum_decimal_display.sv @@
// Channel  | Handshake             | Payload
// request  | push / full           | item   (op, column_lines, row_lines)
// result   | pop / empty           | result (key_code, total, digit_enable, segments)
//
// One result per request. A display tick is answered directly from the idle state.
// For a scan the result is registered on issue, then a bit-serial
// binary-to-decimal conversion of the 32-bit total holds the back end.
// A two-entry queue lets the front take requests while the back end converts.
// Synchronous active-high reset clears counters, total, digits and queue.
module keypad_sum_decimal_display #(
  parameter int NUM_DIGITS       = kssd_pkg::NUM_DIGITS_DEF,
  parameter int DEBOUNCE_SAMPLES = kssd_pkg::DEBOUNCE_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  kssd_pkg::item_t   item,
  input  logic              pop,
  output logic              empty,
  output kssd_pkg::result_t result
);

  logic           q_push;
  logic           q_pop;
  logic           q_nonempty;
  kssd_pkg::cmd_t wr_cmd;
  kssd_pkg::cmd_t rd_cmd;

  kssd_front #(
    .DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (full),
    .q_push (q_push),
    .q_cmd  (wr_cmd)
  );

  kssd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_cmd   (wr_cmd),
    .full     (full),
    .rd       (q_pop),
    .rd_cmd   (rd_cmd),
    .nonempty (q_nonempty)
  );

  kssd_back #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_cmd      (rd_cmd),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule
